[rtl/tsp_pkg.sv]
// Package for typed scan predicate: relation codes, ordering codes, input op codes.
// No dependencies.
package tsp_pkg;
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NUM   = 2'd1,
    OP_START = 2'd2,
    OP_BYTE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } ord_t;

  // depth of the constant string store; byte_index is 6 bits wide
  localparam int MAX_CONST_LEN = 64;

  localparam logic [2:0] REL_EQ    = 3'd0;
  localparam logic [2:0] REL_LT    = 3'd1;
  localparam logic [2:0] REL_LE    = 3'd2;
  localparam logic [2:0] REL_GT    = 3'd3;
  localparam logic [2:0] REL_GE    = 3'd4;
  localparam logic [2:0] REL_NE    = 3'd5;
  localparam logic [2:0] REL_ALWAYS = 3'd6;

  localparam logic [1:0] CFG_ATTR_TYPE = 2'd0;
  localparam logic [1:0] CFG_COMP_OP   = 2'd1;
  localparam logic [1:0] CFG_CONST_NUM = 2'd2;
  localparam logic [1:0] CFG_CONST_LEN = 2'd3;

  localparam logic [1:0] TYPE_REAL = 2'd1;

  function automatic logic relation(input logic [2:0] rel, input logic lt,
                                    input logic eq, input logic gt);
    logic r;
    case (rel)
      REL_EQ:     r = eq;
      REL_LT:     r = lt;
      REL_LE:     r = lt | eq;
      REL_GT:     r = gt;
      REL_GE:     r = gt | eq;
      REL_NE:     r = ~eq;
      REL_ALWAYS: r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

[rtl/tsp_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[rtl/tsp_num_cmp.sv]
// Numeric comparison of attribute against constant: unsigned or IEEE single.
// No dependencies.
module tsp_num_cmp (
  input  logic        is_real,
  input  logic [31:0] a,
  input  logic [31:0] c,
  output logic        lt,
  output logic        eq,
  output logic        gt
);
  logic a_nan, c_nan, a_zero, c_zero, mag_lt, mag_eq;
  logic f_lt, f_eq;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    c_nan  = (c[30:23] == 8'hFF) && (c[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    c_zero = (c[30:0] == 31'd0);
    mag_lt = a[30:0] < c[30:0];
    mag_eq = a[30:0] == c[30:0];
    f_eq = (a_zero && c_zero) || (mag_eq && a[31] == c[31]);
    if (a_zero && c_zero) begin
      f_lt = 1'b0;
    end else if (a[31] != c[31]) begin
      f_lt = a[31];
    end else if (a[31]) begin
      f_lt = !mag_lt && !mag_eq;
    end else begin
      f_lt = mag_lt;
    end
    if (is_real) begin
      if (a_nan || c_nan) begin
        lt = 1'b0; eq = 1'b0; gt = 1'b0;
      end else begin
        lt = f_lt; eq = f_eq; gt = !f_lt && !f_eq;
      end
    end else begin
      lt = a < c; eq = a == c; gt = a > c;
    end
  end
endmodule

[rtl/typed_scan_predicate_top.sv]
// Top level of typed scan predicate: input stage, constant string RAM,
// compare logic and output register. Uses tsp_pkg, tsp_ram, tsp_num_cmp.
//
// One input transaction per cycle unless a result is stalled. The input register
// loads at the accepting edge and reads the constant byte RAM; the relation is
// evaluated from it into the output register, so a result passes the input
// register and then the output register. A result held by out_tready low
// stalls the input stage and drops in_tready for as long as it waits. The
// varchar state is updated as the input stage drains; a byte read from RAM is
// bypassed when a load to the same index is draining at the read edge.
// No clearing pass is needed.
module typed_scan_predicate_top #(
  parameter int PAGE_BYTES    = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // {attr_length[58:46], attr_number[45:14], data_byte[13:6], byte_index[5:0]}
  input  logic [63:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // match
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(tsp_pkg::MAX_CONST_LEN);
  localparam int LW = $clog2(PAGE_BYTES + 1);

  logic [1:0]  attr_type_r;
  logic [2:0]  comp_op_r;
  logic [31:0] const_number_r;
  logic [6:0]  const_length_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_type_r    <= '0;
      comp_op_r      <= tsp_pkg::REL_ALWAYS;
      const_number_r <= '0;
      const_length_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsp_pkg::CFG_ATTR_TYPE: attr_type_r    <= cfg_data[1:0];
        tsp_pkg::CFG_COMP_OP:   comp_op_r      <= cfg_data[2:0];
        tsp_pkg::CFG_CONST_NUM: const_number_r <= cfg_data;
        tsp_pkg::CFG_CONST_LEN: const_length_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // stage 1
  logic        s1_v_r;
  logic [1:0]  s1_op_r;
  logic [5:0]  s1_idx_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_num_r;
  logic [12:0] s1_len_r;
  logic        out_v_r, out_m_r;
  logic        adv;

  assign adv = !out_v_r || out_tready;
  assign in_tready = adv;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  logic        s1_load;
  assign s1_load = s1_v_r && s1_op_r == tsp_pkg::OP_LOAD &&
                   (32'(s1_idx_r) < 32'(tsp_pkg::MAX_CONST_LEN));

  // string state (updated when stage 1 is consumed)
  logic [LW-1:0] pos_r, slen_r;
  logic [1:0]    ord_r;
  logic          in_str_r;

  // RAM read address: position of next byte. Next byte is read at pos_nxt when the stage advances, else at pos_r.
  logic [LW-1:0] pos_nxt, slen_nxt;
  logic [1:0]    ord_nxt;
  logic          in_str_nxt;
  logic          res_v, res_m;
  logic [7:0]    ram_q, cbyte;
  logic [7:0]    byp_data_r;
  logic          byp_r;
  logic [AW-1:0] rd_addr;

  logic clen_gt;
  logic [LW-1:0] clen;
  assign clen_gt = 32'(const_length_r) > 32'(tsp_pkg::MAX_CONST_LEN);
  assign clen = clen_gt ? LW'(tsp_pkg::MAX_CONST_LEN) : LW'(const_length_r);

  logic lt, eq, gt;
  tsp_num_cmp u_cmp (
    .is_real(attr_type_r == tsp_pkg::TYPE_REAL),
    .a(s1_num_r), .c(const_number_r), .lt(lt), .eq(eq), .gt(gt)
  );

  assign cbyte = byp_r ? byp_data_r : ram_q;

  always_comb begin
    logic [LW-1:0] alen;
    logic [1:0]    o;
    logic [LW:0]   p1;
    alen = (32'(s1_len_r) > 32'(PAGE_BYTES)) ? LW'(PAGE_BYTES) : LW'(s1_len_r);
    pos_nxt = pos_r; slen_nxt = slen_r; ord_nxt = ord_r; in_str_nxt = in_str_r;
    res_v = 1'b0; res_m = 1'b0;
    o = ord_r;
    p1 = '0;
    if (s1_v_r) begin
      case (s1_op_r)
        tsp_pkg::OP_NUM: begin
          res_v = 1'b1;
          res_m = tsp_pkg::relation(comp_op_r, lt, eq, gt);
        end
        tsp_pkg::OP_START: begin
          slen_nxt = alen; pos_nxt = '0; ord_nxt = tsp_pkg::ORD_EQUAL;
          in_str_nxt = 1'b1;
          if (alen == '0) begin
            o = (clen != '0) ? tsp_pkg::ORD_LESS : tsp_pkg::ORD_EQUAL;
            in_str_nxt = 1'b0; res_v = 1'b1;
            res_m = tsp_pkg::relation(comp_op_r, o == tsp_pkg::ORD_LESS,
                      o == tsp_pkg::ORD_EQUAL, o == tsp_pkg::ORD_GREATER);
          end
        end
        tsp_pkg::OP_BYTE: begin
          if (in_str_r) begin
            if (ord_r == tsp_pkg::ORD_EQUAL && pos_r < clen) begin
              if (s1_byte_r < cbyte) o = tsp_pkg::ORD_LESS;
              else if (s1_byte_r > cbyte) o = tsp_pkg::ORD_GREATER;
            end
            p1 = {1'b0, pos_r} + 1'b1;
            pos_nxt = p1[LW-1:0];
            ord_nxt = o;
            if (p1 >= {1'b0, slen_r}) begin
              if (o == tsp_pkg::ORD_EQUAL && slen_r != clen) begin
                o = (slen_r < clen) ? tsp_pkg::ORD_LESS : tsp_pkg::ORD_GREATER;
              end
              ord_nxt = o;
              in_str_nxt = 1'b0; res_v = 1'b1;
              res_m = tsp_pkg::relation(comp_op_r, o == tsp_pkg::ORD_LESS,
                        o == tsp_pkg::ORD_EQUAL, o == tsp_pkg::ORD_GREATER);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // read address: position used by the item now entering stage 1
  logic [LW-1:0] pos_eff;
  assign pos_eff = adv ? pos_nxt : pos_r;
  assign rd_addr = pos_eff[AW-1:0];

  tsp_ram #(.WIDTH(8), .DEPTH(tsp_pkg::MAX_CONST_LEN)) u_ram (
    .clk(clk),
    .wr_en(s1_load && adv),
    .wr_addr(s1_idx_r[AW-1:0]),
    .wr_data(s1_byte_r),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  logic byp_nxt;
  logic [7:0] byp_data_nxt;
  always_comb begin
    byp_nxt = byp_r; byp_data_nxt = byp_data_r;
    if (adv) begin
      byp_nxt = 1'b0;
      if (s1_load && s1_idx_r[AW-1:0] == rd_addr) begin
        byp_nxt = 1'b1; byp_data_nxt = s1_byte_r;
      end
    end else if (byp_r == 1'b0) begin
      byp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pos_r    <= '0;
      slen_r   <= '0;
      ord_r    <= tsp_pkg::ORD_EQUAL;
      in_str_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
      if (adv) begin
        s1_v_r   <= in_acc;
        pos_r    <= pos_nxt;
        slen_r   <= slen_nxt;
        ord_r    <= ord_nxt;
        in_str_r <= in_str_nxt;
        out_v_r  <= res_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= byp_data_nxt;
    if (adv) begin
      s1_op_r   <= in_tuser;
      s1_idx_r  <= in_tdata[5:0];
      s1_byte_r <= in_tdata[13:6];
      s1_num_r  <= in_tdata[45:14];
      s1_len_r  <= in_tdata[58:46];
      out_m_r   <= res_m;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_m_r};
endmodule

[tb/sv/tb_typed_scan_predicate_checker.sv]
// Checker for typed scan predicate: watches input, config and result channels,
// predicts the match bit and compares it with the block. Uses tsp_pkg.
module tb_typed_scan_predicate_checker
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          match_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CONST_DEPTH = 64;
  localparam int PAGE_LIMIT  = 4096;

  logic [1:0]  sel_type;
  logic [2:0]  sel_rel;
  logic [31:0] key_number;
  logic [6:0]  key_length;
  logic [7:0]  key_bytes [CONST_DEPTH];
  logic [12:0] scan_pos;
  logic [12:0] scan_len;
  ord_t        scan_order;
  logic        scanning;
  logic        expected_match [$];

  function automatic logic rel_of(logic lt, logic eq, logic gt);
    case (sel_rel)
      REL_EQ:     return eq;
      REL_LT:     return lt;
      REL_LE:     return lt | eq;
      REL_GT:     return gt;
      REL_GE:     return gt | eq;
      REL_NE:     return ~eq;
      REL_ALWAYS: return 1'b1;
      default:    return 1'b0;
    endcase
  endfunction

  // returns -2 when unordered (NaN), else -1/0/1
  function automatic int real_order(logic [31:0] a, logic [31:0] c);
    logic a_nan, c_nan;
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 0);
    c_nan = (c[30:23] == 8'hff) && (c[22:0] != 0);
    if (a_nan || c_nan) return -2;
    if (a[30:0] == 0 && c[30:0] == 0) return 0;
    if (a == c) return 0;
    if (a[31] != c[31]) return a[31] ? -1 : 1;
    if (!a[31]) return (a[30:0] < c[30:0]) ? -1 : 1;
    return (a[30:0] > c[30:0]) ? -1 : 1;
  endfunction

  function automatic logic close_string();
    int klen;
    klen = (key_length > CONST_DEPTH) ? CONST_DEPTH : key_length;
    if (scan_order == ORD_EQUAL && scan_len != klen)
      scan_order = (scan_len < klen) ? ORD_LESS : ORD_GREATER;
    scanning = 1'b0;
    return rel_of(scan_order == ORD_LESS, scan_order == ORD_EQUAL,
                  scan_order == ORD_GREATER);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sel_type <= '0; sel_rel <= REL_ALWAYS; key_number <= '0; key_length <= '0;
      scan_pos = '0; scan_len = '0; scan_order = ORD_EQUAL; scanning = 1'b0;
      expected_match.delete();
      fail_count <= 0; pending <= 0; match_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATTR_TYPE: sel_type <= cfg_data[1:0];
          CFG_COMP_OP:   sel_rel <= cfg_data[2:0];
          CFG_CONST_NUM: key_number <= cfg_data;
          CFG_CONST_LEN: key_length <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        logic [5:0] idx;
        logic [7:0] dbyte;
        logic [31:0] anum;
        logic [12:0] alen;
        int ro, klen;
        idx = in_tdata[5:0]; dbyte = in_tdata[13:6];
        anum = in_tdata[45:14]; alen = in_tdata[58:46];
        klen = (key_length > CONST_DEPTH) ? CONST_DEPTH : key_length;
        case (op_t'(in_tuser))
          OP_LOAD: key_bytes[idx] = dbyte;
          OP_NUM: begin
            if (sel_type == TYPE_REAL) begin
              ro = real_order(anum, key_number);
              expected_match.push_back(ro == -2 ? rel_of(1'b0, 1'b0, 1'b0) :
                                       rel_of(ro == -1, ro == 0, ro == 1));
            end else
              expected_match.push_back(rel_of(anum < key_number, anum == key_number,
                                              anum > key_number));
          end
          OP_START: begin
            scan_len = (alen > PAGE_LIMIT) ? 13'(PAGE_LIMIT) : alen;
            scan_pos = 0; scan_order = ORD_EQUAL; scanning = 1'b1;
            if (scan_len == 0) expected_match.push_back(close_string());
          end
          OP_BYTE: if (scanning) begin
            if (scan_order == ORD_EQUAL && scan_pos < klen) begin
              if (dbyte < key_bytes[scan_pos]) scan_order = ORD_LESS;
              else if (dbyte > key_bytes[scan_pos]) scan_order = ORD_GREATER;
            end
            scan_pos = scan_pos + 13'd1;
            if (scan_pos >= scan_len) expected_match.push_back(close_string());
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        int errs;
        logic e;
        errs = 0;
        if (expected_match.size() == 0) begin
          $error("unexpected result transaction, match=%0d", out_tdata[0]);
          errs++;
        end else begin
          e = expected_match.pop_front();
          if (out_tdata[0] !== e) begin
            $error("match mismatch: expected %0d actual %0d", e, out_tdata[0]);
            errs++;
          end
          if (out_tdata[7:1] !== 7'd0) begin
            $error("out_tdata pad mismatch: expected 0 actual %0h", out_tdata[7:1]);
            errs++;
          end
          match_count <= match_count + 1;
        end
        fail_count <= fail_count + errs;
      end
      pending <= expected_match.size();
    end
  end
endmodule

[tb/sv/tb_typed_scan_predicate_top.sv]
// Testbench top for typed scan predicate: clock, reset, stimulus and verdict.
// Depends on tsp_pkg, typed_scan_predicate_top and the checker module.
module tb_typed_scan_predicate_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [63:0] in_tdata;
  logic [1:0] in_tuser, cfg_index;
  logic [7:0] out_tdata;
  logic [31:0] cfg_data;
  int fail_count, pending, match_count;
  bit quiet;
  int sent;
  logic [7:0] key_image [64];
  int key_len;
  int stall_left;

  typed_scan_predicate_top dut (.*);
  tb_typed_scan_predicate_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side backpressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 3));
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send(op_t op, logic [5:0] idx, logic [7:0] b, logic [31:0] num,
                      logic [12:0] len);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'd0, len, num, b, idx};
    @(posedge clk iff in_tready);
    sent++;
  endtask

  task automatic idle_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CONST_LEN) key_len = (val[6:0] > 64) ? 64 : val[6:0];
  endtask

  task automatic load_key(int n, bit all_ones);
    for (int i = 0; i < n; i++) begin
      key_image[i] = all_ones ? 8'hff : 8'($urandom_range(0, 255));
      send(OP_LOAD, 6'(i), key_image[i], $urandom, 13'($urandom));
    end
  endtask

  // string with length near the key and content near it
  task automatic send_string(int len);
    bit diverged;
    send(OP_START, 6'($urandom), 8'($urandom), $urandom, 13'(len));
    diverged = 0;
    for (int i = 0; i < len; i++) begin
      logic [7:0] b;
      if (i < 64 && !diverged && $urandom_range(0, 9) != 0) b = key_image[i];
      else begin b = 8'($urandom); diverged = 1; end
      if ($urandom_range(0, 30) == 0)
        send(OP_NUM, 6'($urandom), 8'($urandom), $urandom, 13'($urandom));
      send(OP_BYTE, 6'($urandom), b, $urandom, 13'($urandom));
    end
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fc0_0001;
      3: return 32'h7f80_0000;
      4: return 32'hff80_0000;
      5: return 32'h3f80_0000;
      6: return 32'hbf80_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = OP_LOAD;
    cfg_valid = 0; cfg_index = CFG_ATTR_TYPE; cfg_data = '0;
    quiet = 0; sent = 0; key_len = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config (always), numeric extremes, strings
    send(OP_NUM, 6'd63, 8'hff, 32'hffff_ffff, 13'h1fff);
    send(OP_BYTE, 6'd0, 8'h00, 32'h0, 13'd0);
    send(OP_START, 6'd0, 8'h00, 32'h0, 13'd0);
    load_key(64, 1);
    send(OP_LOAD, 6'd63, 8'h00, 32'h0, 13'd0);
    key_image[63] = 8'h00;
    idle_wait();
    write_reg(CFG_ATTR_TYPE, 32'd0);
    write_reg(CFG_COMP_OP, 32'(REL_LT));
    write_reg(CFG_CONST_NUM, 32'hffff_ffff);
    write_reg(CFG_CONST_LEN, 32'd127);
    send(OP_NUM, 6'd0, 8'h0, 32'h0, 13'd0);
    send(OP_NUM, 6'd0, 8'h0, 32'hffff_ffff, 13'd0);
    send(OP_START, 6'd0, 8'h0, 32'h0, 13'h1fff);
    send(OP_BYTE, 6'd0, 8'hff, 32'h0, 13'd0);
    send(OP_START, 6'd0, 8'h0, 32'h0, 13'd2);
    send(OP_BYTE, 6'd0, 8'hff, 32'h0, 13'd0);
    send(OP_LOAD, 6'd1, 8'h10, 32'h0, 13'd0);
    key_image[1] = 8'h10;
    send(OP_BYTE, 6'd0, 8'h10, 32'h0, 13'd0);
    idle_wait();
    write_reg(CFG_ATTR_TYPE, 32'(TYPE_REAL));
    write_reg(CFG_COMP_OP, 32'(REL_NE));
    write_reg(CFG_CONST_NUM, 32'h7fc0_0000);
    send(OP_NUM, 6'd0, 8'h0, 32'h7fc0_0000, 13'd0);
    idle_wait();
    write_reg(CFG_COMP_OP, 32'(REL_EQ));
    write_reg(CFG_CONST_NUM, 32'h8000_0000);
    send(OP_NUM, 6'd0, 8'h0, 32'h0, 13'd0);
    idle_wait();

    // random phases; two of them use a long or saturated constant length
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_ATTR_TYPE, 32'($urandom_range(0, 3)));
      write_reg(CFG_COMP_OP, 32'($urandom_range(0, 7)));
      write_reg(CFG_CONST_NUM, pick_float());
      write_reg(CFG_CONST_LEN, (ph % 6 == 0) ? 32'd0 :
                               (ph % 6 == 3) ? 32'($urandom_range(60, 70)) :
                                               32'($urandom_range(1, 16)));
      if (ph % 6 == 0) load_key(64, 0);
      if (ph == 10) quiet = 1;
      for (int k = 0; k < 8; k++) begin
        int slen;
        slen = key_len + int'($urandom_range(0, 4)) - 2;
        if (slen < 0) slen = 0;
        case ($urandom_range(0, 9))
          0, 1, 2: send(OP_NUM, 6'($urandom), 8'($urandom), pick_float(),
                        13'($urandom));
          3: send(OP_LOAD, 6'($urandom_range(0, 63)), 8'($urandom), $urandom,
                  13'($urandom));
          4: send(OP_BYTE, 6'($urandom), 8'($urandom), $urandom, 13'($urandom));
          5: begin
            send(OP_START, 6'($urandom), 8'($urandom), $urandom, 13'd5);
            send(OP_BYTE, 6'($urandom), key_image[0], $urandom, 13'($urandom));
          end
          default: send_string(slen);
        endcase
      end
      idle_wait();
    end

    idle_wait();
    repeat (20) @(posedge clk);
    $display("Covered integer, real and varchar compares over 12 config phases with stalls;");
    $display("sent %0d input transactions and checked %0d results.", sent, match_count);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[typed_scan_predicate_top.f]
rtl/tsp_pkg.sv
rtl/tsp_ram.sv
rtl/tsp_num_cmp.sv
rtl/typed_scan_predicate_top.sv
tb/sv/tb_typed_scan_predicate_checker.sv
tb/sv/tb_typed_scan_predicate_top.sv
